@@ src/ising_pkg.sv @@
// ----------------------------------------------------------------------------
// ising_pkg
// Types and codes shared by the lattice update controller and datapath.
// ----------------------------------------------------------------------------
package ising_pkg;

    localparam int IN_TDATA_W  = 48;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 8;
    localparam int CFG_DATA_W  = 32;

    // configuration register indexes
    localparam logic CFG_THR_FOUR  = 1'b0;
    localparam logic CFG_THR_EIGHT = 1'b1;

    typedef enum logic [1:0] {
        CMD_UPDATE = 2'd0,
        CMD_READ   = 2'd1,
        CMD_WRITE  = 2'd2
    } t_command;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_NBR,
        S_EXEC
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clr_wr;   // write one zero row of the clearing pass
        logic accept;   // take the item, read center row and row above
        logic rd_down;  // read row below
        logic exec;     // decide, write back row, load result
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic out_free;
    } t_dp_stat;

endpackage

@@ src/ising_ctrl.sv @@
// ----------------------------------------------------------------------------
// ising_ctrl
// Sequencer for clearing pass, neighbor row reads and the update step.
// ----------------------------------------------------------------------------
module ising_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ising_pkg::t_dp_stat i_stat,
    output ising_pkg::t_dp_cmd  o_cmd
);
    import ising_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_NBR;
            end
            S_NBR: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                // hold until the result register can take the item
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd          = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
            end
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_NBR: begin
                o_cmd.rd_down = 1'b1;
            end
            S_EXEC: begin
                o_cmd.exec = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

@@ src/ising_datapath.sv @@
// ----------------------------------------------------------------------------
// ising_datapath
// Row memory of the lattice, neighbor gathering, acceptance and result register.
// ----------------------------------------------------------------------------
module ising_datapath #(
    parameter int SIDE = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  ising_pkg::t_dp_cmd                   i_cmd,
    output ising_pkg::t_dp_stat                  o_stat,
    input  logic [ising_pkg::IN_TDATA_W-1:0]     i_in_data,
    input  logic [ising_pkg::IN_TUSER_W-1:0]     i_in_user,
    input  logic                                 i_cfg_wen,
    input  logic                                 i_cfg_index,
    input  logic [ising_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [ising_pkg::OUT_TDATA_W-1:0]    o_out_data
);
    import ising_pkg::*;

    localparam int XW = $clog2(SIDE);

    // coordinate wrap table for the 6-bit site fields
    logic [XW-1:0] w_mod [64];
    for (genvar gi = 0; gi < 64; gi++) begin : g_mod
        assign w_mod[gi] = XW'(gi % SIDE);
    end

    logic [31:0]     r_thr_four;
    logic [31:0]     r_thr_eight;
    logic [SIDE-1:0] r_lattice [SIDE];
    logic [SIDE-1:0] r_rd_a;
    logic [SIDE-1:0] r_rd_b;
    logic [XW-1:0]   r_clr_row;
    logic [XW-1:0]   r_x;
    logic [XW-1:0]   r_y;
    t_command        r_cmd;
    logic [31:0]     r_rnd;
    logic            r_spin_in;
    logic            r_up;
    logic            r_out_valid;
    logic            r_out_spin;
    logic            r_out_flip;
    logic [4:0]      r_out_de;

    logic [XW-1:0]   w_in_x;
    logic [XW-1:0]   w_in_y;
    logic [XW-1:0]   w_in_y_up;
    logic [XW-1:0]   w_x_l;
    logic [XW-1:0]   w_x_r;
    logic [XW-1:0]   w_y_dn;
    logic            w_center;
    logic [2:0]      w_agree;
    logic [4:0]      w_de;
    logic            w_accept;
    logic            w_new_spin;
    logic            w_flip;
    logic [4:0]      w_de_out;
    logic [SIDE-1:0] w_row;
    logic            w_mem_we;
    logic [XW-1:0]   w_mem_waddr;
    logic [SIDE-1:0] w_mem_wdata;
    logic [XW-1:0]   w_rd_b_addr;

    assign w_in_x    = w_mod[i_in_data[5:0]];
    assign w_in_y    = w_mod[i_in_data[11:6]];
    assign w_in_y_up = (w_in_y == '0) ? XW'(SIDE - 1) : w_in_y - XW'(1);
    assign w_x_l     = (r_x == '0) ? XW'(SIDE - 1) : r_x - XW'(1);
    assign w_x_r     = (r_x == XW'(SIDE - 1)) ? '0 : r_x + XW'(1);
    assign w_y_dn    = (r_y == XW'(SIDE - 1)) ? '0 : r_y + XW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_four  <= '0;
            r_thr_eight <= '0;
        end else if (i_cfg_wen) begin
            case (i_cfg_index)
                CFG_THR_FOUR:  r_thr_four  <= i_cfg_wdata;
                CFG_THR_EIGHT: r_thr_eight <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_row <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_row <= r_clr_row + XW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_x       <= w_in_x;
            r_y       <= w_in_y;
            r_cmd     <= t_command'(i_in_user);
            r_rnd     <= i_in_data[43:12];
            r_spin_in <= i_in_data[44];
        end
        if (i_cmd.rd_down) begin
            r_up <= r_rd_b[r_x];
        end
    end

    // decision on the center row (port A), the row above (held from port B) and the row below (port B)
    assign w_center = r_rd_a[r_x];
    assign w_agree  = 3'(r_rd_a[w_x_l] == w_center) + 3'(r_rd_a[w_x_r] == w_center)
                    + 3'(r_up == w_center) + 3'(r_rd_b[r_x] == w_center);
    assign w_de     = 5'({1'b0, w_agree, 2'b00} - 6'd8);

    always_comb begin
        case (w_agree)
            3'd3:    w_accept = r_rnd < r_thr_four;
            3'd4:    w_accept = r_rnd < r_thr_eight;
            default: w_accept = 1'b1;
        endcase
    end

    always_comb begin
        w_new_spin = w_center;
        w_flip     = 1'b0;
        w_de_out   = '0;
        case (r_cmd)
            CMD_UPDATE: begin
                w_flip     = w_accept;
                w_new_spin = w_center ^ w_accept;
                w_de_out   = w_de;
            end
            CMD_WRITE: begin
                w_new_spin = r_spin_in;
            end
            default: begin
                w_new_spin = w_center;
            end
        endcase
    end

    always_comb begin
        w_row        = r_rd_a;
        w_row[r_x]   = w_new_spin;
    end

    assign w_mem_we    = i_cmd.clr_wr | i_cmd.exec;
    assign w_mem_waddr = i_cmd.clr_wr ? r_clr_row : r_y;
    assign w_mem_wdata = i_cmd.clr_wr ? '0 : w_row;
    assign w_rd_b_addr = i_cmd.accept ? w_in_y_up : w_y_dn;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_lattice[w_mem_waddr] <= w_mem_wdata;
        end
        if (i_cmd.accept) begin
            r_rd_a <= r_lattice[w_in_y];
        end
        if (i_cmd.accept || i_cmd.rd_down) begin
            r_rd_b <= r_lattice[w_rd_b_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out_spin <= w_new_spin;
            r_out_flip <= w_flip;
            r_out_de   <= w_de_out;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_data      = {1'b0, r_out_de, r_out_flip, r_out_spin};
    assign o_stat.clr_last = (r_clr_row == XW'(SIDE - 1));
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    a_no_write_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.clr_wr && (i_cmd.exec || i_cmd.accept)))
        else $error("clearing pass overlaps item traffic");

    a_exec_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over an unread result");

    a_exec_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |=> r_out_valid)
        else $error("result not presented after update step");

    a_quiet_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && r_cmd != CMD_UPDATE) |=> (!r_out_flip && r_out_de == '0))
        else $error("read or write reported a flip or energy");

endmodule

@@ src/ising_metropolis_update.sv @@
// ----------------------------------------------------------------------------
// ising_metropolis_update
// Metropolis update, read and write of a periodic square lattice of spins.
// ----------------------------------------------------------------------------
// The lattice of SIDE x SIDE one-bit spins sits in a row memory, one word of
// SIDE bits per row, with two read ports. An item passes from acceptance to a
// loaded result as follows: the accept step reads the site's row and the row
// above, the following state reads the row below, and the update step decides
// the flip, writes the row back and loads the result register. Three rows per
// item over two read ports need the separate read of the row below. A new item
// is taken while a result still waits; the update step holds until the result
// register is free. After reset a clearing pass sets all spins down, during
// which no item is accepted; threshold writes are taken at any time.
module ising_metropolis_update #(
    parameter int SIDE = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // site_x[5:0], site_y[11:6], random_word[43:12], spin_in[44], zero pad
    input  logic [ising_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // command[1:0]
    input  logic [ising_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // spin_out[0], flipped[1], energy_change[6:2], zero pad
    output logic [ising_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  logic                                i_cfg_wen,
    input  logic                                i_cfg_index,
    input  logic [ising_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);
    import ising_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    ising_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    ising_datapath #(
        .SIDE (SIDE)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule
